[rtl/core/mono_bit_blit_framebuffer_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the monochrome bit blit core
// Shared forms for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef MONO_BIT_BLIT_FRAMEBUFFER_CORE_ASSERT_SVH
`define MONO_BIT_BLIT_FRAMEBUFFER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MBBF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MBBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/mbbf_pkg.sv]
// ----------------------------------------------------------------------------
// Monochrome bit blit package
// Screen geometry, item layouts, command codes and state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package mbbf_pkg;

	// Screen geometry; the framebuffer holds SCREEN_HEIGHT rows of packed bytes.
	localparam int SCREEN_WIDTH  = 240;
	localparam int SCREEN_HEIGHT = 120;
	localparam int LINE_BYTES    = SCREEN_WIDTH / 8;
	localparam int STORE_BYTES   = LINE_BYTES * SCREEN_HEIGHT;
	localparam int ADDR_W        = $clog2(STORE_BYTES);

	// Command queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Operation codes of an input item.
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_SRC   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// Input item.
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] pos_x;
		logic [6:0] pos_y;
		logic [7:0] width_px;
		logic [6:0] height_rows;
		logic       invert;
		logic [7:0] src_byte;
	} req_t;

	// Result item.
	typedef struct packed {
		logic [7:0] read_data;
		logic       blit_active;
	} rsp_t;

	// Kind of work the back part carries out.
	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_MERGE,
		CMD_READ
	} cmd_kind_t;

	// Classified command passed through the queue.
	typedef struct packed {
		cmd_kind_t         kind;
		logic              v1;       // first byte is on screen
		logic              v2;       // second byte is on screen
		logic              need_rd;  // merge keeps old pixels
		logic [ADDR_W-1:0] addr;
		logic [7:0]        bits1;
		logic [7:0]        keep1;
		logic [7:0]        bits2;
		logic [7:0]        keep2;
		logic              active;
	} cmd_t;

	// Back part sequencer states.
	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_MERGE1,
		BK_MERGE2,
		BK_READ,
		BK_HOLD
	} back_state_t;

endpackage

`default_nettype wire

[rtl/core/mbbf_in_if.sv]
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel that carries one blit command item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbbf_in_if;
	import mbbf_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/mbbf_out_if.sv]
// ----------------------------------------------------------------------------
// Result item channel
// Valid/ready channel that carries one result item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbbf_out_if;
	import mbbf_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/mbbf_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mbbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/core/mbbf_front.sv]
// ----------------------------------------------------------------------------
// Blit front end
// Accepts items, tracks blit position and classifies each item into a
// framebuffer command with addresses, shifted pixels and merge masks.
// ----------------------------------------------------------------------------
`default_nettype none

module mbbf_front (
	input  logic           clk,
	input  logic           arst_n,
	mbbf_in_if.sink        req,
	input  logic           clearing,
	input  logic           q_full,
	output logic           push,
	output mbbf_pkg::cmd_t push_cmd
);
	import mbbf_pkg::*;

	logic       acc;
	req_t       d;

	// Blit state.
	logic [4:0] start_col_q, start_col_d;
	logic [6:0] start_row_q, start_row_d;
	logic [2:0] bit_off_q, bit_off_d;
	logic [4:0] row_bytes_q, row_bytes_d;
	logic [6:0] rows_total_q, rows_total_d;
	logic       invert_q, invert_d;
	logic [6:0] row_cnt_q, row_cnt_d;
	logic [4:0] col_cnt_q, col_cnt_d;
	logic       active_q, active_d;

	logic [7:0]        src_b;
	logic [3:0]        left_shift;
	logic [7:0]        bits1, keep1, bits2, keep2;
	logic [7:0]        row_sum;
	logic [5:0]        col_sum, col_nxt;
	logic              row_ok, blit_v1, blit_v2;
	logic [ADDR_W-1:0] blit_addr, rd_addr;
	logic [4:0]        rd_col;
	logic              rd_v;
	logic [4:0]        col_inc;
	logic [6:0]        row_inc;

	assign d        = req.data;
	assign req.ready = !clearing && !q_full;
	assign acc      = req.valid && req.ready;
	assign push     = acc && (d.op != OP_NONE);

	// Destination of the current source byte.
	always_comb begin
		row_sum   = {1'b0, start_row_q} + {1'b0, row_cnt_q};
		col_sum   = {1'b0, start_col_q} + {1'b0, col_cnt_q};
		col_nxt   = col_sum + 6'd1;
		row_ok    = int'(row_sum) < SCREEN_HEIGHT;
		blit_v1   = row_ok && (int'(col_sum) < LINE_BYTES);
		blit_v2   = row_ok && (int'(col_nxt) < LINE_BYTES);
		blit_addr = ADDR_W'(int'(row_sum) * LINE_BYTES + int'(col_sum));
	end

	// Read address.
	always_comb begin
		rd_col  = d.pos_x[7:3];
		rd_v    = (int'(d.pos_y) < SCREEN_HEIGHT) && (int'(rd_col) < LINE_BYTES);
		rd_addr = ADDR_W'(int'(d.pos_y) * LINE_BYTES + int'(rd_col));
	end

	// Pixel alignment: the byte splits across two destination bytes.
	always_comb begin
		src_b      = invert_q ? ~d.src_byte : d.src_byte;
		left_shift = 4'd8 - {1'b0, bit_off_q};
		bits1      = src_b >> bit_off_q;
		keep1      = (bit_off_q == 3'd0) ? 8'h00 : (8'hff << left_shift);
		bits2      = src_b << left_shift;
		keep2      = 8'hff >> bit_off_q;
	end

	// Classification and next blit state.
	always_comb begin
		start_col_d  = start_col_q;
		start_row_d  = start_row_q;
		bit_off_d    = bit_off_q;
		row_bytes_d  = row_bytes_q;
		rows_total_d = rows_total_q;
		invert_d     = invert_q;
		row_cnt_d    = row_cnt_q;
		col_cnt_d    = col_cnt_q;
		active_d     = active_q;
		col_inc      = col_cnt_q + 5'd1;
		row_inc      = row_cnt_q + 7'd1;

		push_cmd         = '0;
		push_cmd.kind    = CMD_NOP;
		push_cmd.addr    = blit_addr;
		push_cmd.bits1   = bits1;
		push_cmd.keep1   = keep1;
		push_cmd.bits2   = bits2;
		push_cmd.keep2   = keep2;

		case (d.op)
			OP_START: begin
				start_col_d  = d.pos_x[7:3];
				start_row_d  = d.pos_y;
				bit_off_d    = d.pos_x[2:0];
				row_bytes_d  = d.width_px[7:3];
				rows_total_d = d.height_rows;
				invert_d     = d.invert;
				row_cnt_d    = '0;
				col_cnt_d    = '0;
				active_d     = (d.width_px[7:3] != 5'd0) && (d.height_rows != 7'd0);
			end
			OP_SRC: begin
				if (active_q) begin
					push_cmd.kind    = CMD_MERGE;
					push_cmd.v1      = blit_v1;
					push_cmd.v2      = blit_v2;
					push_cmd.need_rd = (bit_off_q != 3'd0);
					if (col_inc >= row_bytes_q) begin
						col_cnt_d = '0;
						row_cnt_d = row_inc;
						if (row_inc >= rows_total_q) begin
							active_d = 1'b0;
						end
					end else begin
						col_cnt_d = col_inc;
					end
				end
			end
			OP_READ: begin
				push_cmd.kind = CMD_READ;
				push_cmd.v1   = rd_v;
				push_cmd.addr = rd_addr;
			end
			default: begin
			end
		endcase

		push_cmd.active = active_d;
	end

	// Blit state registers, updated on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_col_q  <= '0;
			start_row_q  <= '0;
			bit_off_q    <= '0;
			row_bytes_q  <= '0;
			rows_total_q <= '0;
			invert_q     <= 1'b0;
			row_cnt_q    <= '0;
			col_cnt_q    <= '0;
			active_q     <= 1'b0;
		end else if (acc) begin
			start_col_q  <= start_col_d;
			start_row_q  <= start_row_d;
			bit_off_q    <= bit_off_d;
			row_bytes_q  <= row_bytes_d;
			rows_total_q <= rows_total_d;
			invert_q     <= invert_d;
			row_cnt_q    <= row_cnt_d;
			col_cnt_q    <= col_cnt_d;
			active_q     <= active_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/mbbf_queue.sv]
// ----------------------------------------------------------------------------
// Command queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mbbf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mbbf_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output mbbf_pkg::cmd_t head
);
	import mbbf_pkg::*;

	cmd_t              ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full       = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = ent_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/mbbf_back.sv]
// ----------------------------------------------------------------------------
// Blit back end
// Clears the framebuffer after reset, then carries out queued commands by write,
// read-modify-write or read of the framebuffer and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbbf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  mbbf_pkg::cmd_t head,
	output logic           pop,
	output logic           clearing,
	mbbf_out_if.source     rsp
);
	import mbbf_pkg::*;

	back_state_t       state_q, state_d;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              rsp_valid_q;
	rsp_t              rsp_data_q;

	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr, addr2;
	logic [7:0]        wdata, rdata;
	logic              finish, emit, out_free;
	rsp_t              res_data;

	mbbf_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_frame_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign clearing  = (state_q == BK_CLEAR);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign addr2     = head.addr + ADDR_W'(1);
	assign pop       = emit;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// Result of the command at the queue head.
	always_comb begin
		res_data.read_data   = (head.kind == CMD_READ && head.v1) ? rdata : 8'h00;
		res_data.blit_active = head.active;
	end

	// Sequencer: next state and memory controls.
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = head.addr;
		wdata   = 8'h00;
		re      = 1'b0;
		raddr   = head.addr;
		finish  = 1'b0;
		emit    = 1'b0;

		case (state_q)
			BK_CLEAR: begin
				we    = 1'b1;
				waddr = clr_addr_q;
				if (clr_addr_q == ADDR_W'(STORE_BYTES - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (head_valid) begin
					case (head.kind)
						CMD_MERGE: begin
							if (!head.v1) begin
								finish = 1'b1;
							end else if (head.need_rd) begin
								re      = 1'b1;
								state_d = BK_MERGE1;
							end else begin
								// Aligned byte replaces the destination outright.
								we     = 1'b1;
								wdata  = head.bits1;
								finish = 1'b1;
							end
						end
						CMD_READ: begin
							if (head.v1) begin
								re      = 1'b1;
								state_d = BK_READ;
							end else begin
								finish = 1'b1;
							end
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
			BK_MERGE1: begin
				// Write the first byte, and fetch the second when it is on screen.
				we    = 1'b1;
				wdata = (rdata & head.keep1) | head.bits1;
				if (head.v2) begin
					re      = 1'b1;
					raddr   = addr2;
					state_d = BK_MERGE2;
				end else begin
					finish = 1'b1;
				end
			end
			BK_MERGE2: begin
				we     = 1'b1;
				waddr  = addr2;
				wdata  = (rdata & head.keep2) | head.bits2;
				finish = 1'b1;
			end
			BK_READ: begin
				finish = 1'b1;
			end
			BK_HOLD: begin
				finish = 1'b1;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase

		// Hand the result over, or wait for the result register to drain.
		if (finish) begin
			if (out_free) begin
				emit    = 1'b1;
				state_d = BK_IDLE;
			end else begin
				state_d = BK_HOLD;
			end
		end
	end

	// State register and clearing address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_CLEAR;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
		end
	end

	// Result register; a new result loads as the old one transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_data_q <= res_data;
		end
	end

endmodule

`default_nettype wire

[rtl/core/mono_bit_blit_framebuffer_core.sv]
// An accepted item is worked on once it heads the queue, and its result goes to the result register.
// Start items, off-screen items and byte-aligned source bytes finish in the idle state; reads pass
// through the read state. Source bytes at a nonzero bit offset read and merge the first byte, then
// the second unless it lies past the row end. One item at a time; a full result register holds it.
// Reset: asynchronous; the framebuffer is then cleared one byte a cycle over all 3600 bytes,
// during which req.ready stays low.
// ----------------------------------------------------------------------------
// Monochrome bit blit framebuffer core
// Front end, command queue and read-modify-write back end around the frame RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_bit_blit_framebuffer_core (
	input  logic        clk,
	input  logic        arst_n,
	mbbf_in_if.sink     req,
	mbbf_out_if.source  rsp
);
	import mbbf_pkg::*;

	logic push, pop, q_full, head_valid, clearing;
	cmd_t push_cmd, head;

	mbbf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.clearing(clearing),
		.q_full  (q_full),
		.push    (push),
		.push_cmd(push_cmd)
	);

	mbbf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (q_full),
		.head_valid(head_valid),
		.head      (head)
	);

	mbbf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.clearing  (clearing),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

[rtl/core/mbbf_checker.sv]
// ----------------------------------------------------------------------------
// Port checker for the monochrome bit blit core
// Watches the core's channels for result handshakes, item counts and reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mono_bit_blit_framebuffer_core_assert.svh"

module mbbf_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic [1:0]     req_op,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input mbbf_pkg::rsp_t rsp_data
);
	import mbbf_pkg::*;

	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 2);
	localparam int MAX_OUT = QUEUE_DEPTH + 1;

	logic             inc, dec;
	logic [CNT_W-1:0] out_cnt_q;

	assign inc = req_valid && req_ready && (req_op != OP_NONE);
	assign dec = rsp_valid && rsp_ready;

	// Items accepted whose result has not yet transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (inc && !dec) begin
			out_cnt_q <= out_cnt_q + CNT_W'(1);
		end else if (dec && !inc) begin
			out_cnt_q <= out_cnt_q - CNT_W'(1);
		end
	end

	// A stalled result stays offered and unchanged.
	`MBBF_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

	// The framebuffer clear blocks input right after reset.
	`MBBF_ASSERT_IMPLY(a_clear_blocks, clk, arst_n, !$past(arst_n), !req_ready, "input taken during clear")

	// No result without an accepted item behind it.
	`MBBF_ASSERT_IMPLY(a_no_spurious, clk, arst_n, rsp_valid, out_cnt_q != '0, "result without item")

	// Items in flight never exceed the queue plus the result register.
	`MBBF_ASSERT_IMPLY(a_bound, clk, arst_n, 1'b1, int'(out_cnt_q) <= MAX_OUT, "too many items in flight")

endmodule

bind mono_bit_blit_framebuffer_core mbbf_checker u_mbbf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.req_op   (req.data.op),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data (rsp.data)
);

`default_nettype wire
